>>> src/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_INS  = 2'd1,
    STEP_DEL  = 2'd2,
    STEP_SCAN = 2'd3
  } step_t;

  typedef struct packed {
    logic  load;
    logic  rd_pos;
    logic  ptr_count;
    logic  ptr_pos;
    logic  ptr_zero;
    step_t step;
    logic  cap_vout;
    logic  write_val;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  cnt_clr;
    logic  set_ok;
    logic  publish;
  } ple_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic pos_zero;
    logic pos_le_cnt;
    logic pos_le_cnt1;
    logic full;
    logic ins_more;
    logic fwd_more;
    logic out_busy;
  } ple_sts_t;

endpackage

>>> src/ple_in_if.sv
// Request channel: valid/ready handshake with command, position and value.
interface ple_in_if import ple_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

>>> src/ple_out_if.sv
// Result channel: valid/ready handshake with status, data and length.
interface ple_out_if import ple_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [VAL_W-1:0] value_out;
  logic [LEN_W-1:0]        found_position;
  logic [LEN_W-1:0]        length_now;
  logic                    is_empty;

  modport source (output valid, output ok, output value_out, output found_position,
                  output length_now, output is_empty, input ready);
  modport sink   (input valid, input ok, input value_out, input found_position,
                  input length_now, input is_empty, output ready);
endinterface

>>> src/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ple_ctrl.sv
// Controller: sequences decode, shift, scan and result hand-off.
module ple_ctrl import ple_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ple_sts_t sts,
  output ple_ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS,
    S_INS_PUT,
    S_DEL_HEAD,
    S_DEL,
    S_GET,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.step  = STEP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (sts.cmd)
          CMD_INSERT: begin
            if (!sts.pos_zero && sts.pos_le_cnt1 && !sts.full) begin
              ctl.ptr_count = 1'b1;
              state_nxt     = S_INS;
            end
          end
          CMD_DELETE: begin
            if (!sts.pos_zero && sts.pos_le_cnt) begin
              ctl.rd_pos  = 1'b1;
              ctl.ptr_pos = 1'b1;
              state_nxt   = S_DEL_HEAD;
            end
          end
          CMD_GET: begin
            if (!sts.pos_zero && sts.pos_le_cnt) begin
              ctl.rd_pos = 1'b1;
              state_nxt  = S_GET;
            end
          end
          CMD_LOCATE: begin
            ctl.ptr_zero = 1'b1;
            ctl.set_ok   = 1'b1;
            state_nxt    = S_SCAN;
          end
          CMD_CLEAR: begin
            ctl.cnt_clr = 1'b1;
            ctl.set_ok  = 1'b1;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_INS: begin
        if (sts.ins_more) begin
          ctl.step = STEP_INS;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ctl.write_val = 1'b1;
        ctl.cnt_inc   = 1'b1;
        ctl.set_ok    = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DEL_HEAD: begin
        ctl.cap_vout = 1'b1;
        if (sts.fwd_more) begin
          ctl.step  = STEP_DEL;
          state_nxt = S_DEL;
        end else begin
          ctl.cnt_dec = 1'b1;
          ctl.set_ok  = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DEL: begin
        if (sts.fwd_more) begin
          ctl.step = STEP_DEL;
        end else begin
          ctl.cnt_dec = 1'b1;
          ctl.set_ok  = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_GET: begin
        ctl.cap_vout = 1'b1;
        ctl.set_ok   = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        if (sts.fwd_more) begin
          ctl.step = STEP_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/ple_dp.sv
// Datapath: element RAM, length, pointer, result and output registers.
module ple_dp import ple_pkg::*; #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ple_ctl_t                ctl,
  output ple_sts_t                sts,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_ok,
  output logic signed [VAL_W-1:0] out_value,
  output logic [LEN_W-1:0]        out_found,
  output logic [LEN_W-1:0]        out_length,
  output logic                    out_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int EW = ELEMENT_WIDTH;

  // request
  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [EW-1:0]    val_r;

  // control state
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;
  logic          chk_r;
  logic [CW-1:0] chk_pos_r;

  // result
  logic          ok_r;
  logic [EW-1:0] vout_r;
  logic [CW-1:0] found_r;

  // output register
  logic                    out_valid_r;
  logic                    out_ok_r;
  logic [VAL_W-1:0]        out_value_r;
  logic [LEN_W-1:0]        out_found_r;
  logic [LEN_W-1:0]        out_len_r;
  logic                    out_empty_r;

  // memory port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [63:0]   in_wide, vout_wide;
  logic [PW-1:0] pos_x, cnt_x, pos_dec;
  logic [CW-1:0] ptr_dec, ptr_inc;

  ple_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_wide = {32'b0, in_value};

  always_comb begin
    vout_wide          = '0;
    vout_wide[EW-1:0]  = vout_r;
  end

  assign pos_x   = PW'(pos_r);
  assign cnt_x   = PW'(count_r);
  assign pos_dec = pos_x - PW'(1);
  assign ptr_dec = ptr_r - CW'(1);
  assign ptr_inc = ptr_r + CW'(1);

  assign sts.cmd         = cmd_t'(cmd_r);
  assign sts.pos_zero    = (pos_r == '0);
  assign sts.pos_le_cnt  = (pos_x <= cnt_x);
  assign sts.pos_le_cnt1 = (pos_x <= cnt_x + PW'(1));
  assign sts.full        = (count_r == CW'(CAPACITY));
  assign sts.ins_more    = (PW'(ptr_r) >= pos_x);
  assign sts.fwd_more    = (ptr_r < count_r);
  assign sts.out_busy    = out_valid_r && !out_ready;

  always_comb begin
    if (ctl.rd_pos) begin
      raddr = pos_dec[AW-1:0];
    end else if (ctl.step == STEP_INS) begin
      raddr = ptr_dec[AW-1:0];
    end else begin
      raddr = ptr_r[AW-1:0];
    end
  end

  assign we    = pend_r || ctl.write_val;
  assign waddr = ctl.write_val ? pos_dec[AW-1:0] : pend_addr_r;
  assign wdata = ctl.write_val ? val_r : rdata;

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctl.ptr_count) begin
      ptr_nxt = count_r;
    end else if (ctl.ptr_pos) begin
      ptr_nxt = CW'(pos_r);
    end else if (ctl.ptr_zero) begin
      ptr_nxt = '0;
    end else begin
      case (ctl.step)
        STEP_INS:  ptr_nxt = ptr_dec;
        STEP_DEL:  ptr_nxt = ptr_inc;
        STEP_SCAN: ptr_nxt = ptr_inc;
        default:   ptr_nxt = ptr_r;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_clr) begin
      count_nxt = '0;
    end else if (ctl.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= (ctl.step == STEP_INS) || (ctl.step == STEP_DEL);
      chk_r   <= (ctl.step == STEP_SCAN);
      if (ctl.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pend_addr_r <= (ctl.step == STEP_INS) ? ptr_r[AW-1:0] : ptr_dec[AW-1:0];
    chk_pos_r   <= ptr_inc;
    if (ctl.load) begin
      cmd_r   <= in_cmd;
      pos_r   <= in_position;
      val_r   <= in_wide[EW-1:0];
      ok_r    <= 1'b0;
      vout_r  <= '0;
      found_r <= '0;
    end else begin
      if (ctl.set_ok) begin
        ok_r <= 1'b1;
      end
      if (ctl.cap_vout) begin
        vout_r <= rdata;
      end
      if (chk_r && (found_r == '0) && (rdata == val_r)) begin
        found_r <= chk_pos_r;
      end
    end
    if (ctl.publish) begin
      out_ok_r    <= ok_r;
      out_value_r <= vout_wide[VAL_W-1:0];
      out_found_r <= LEN_W'(found_r);
      out_len_r   <= LEN_W'(count_r);
      out_empty_r <= (count_r == '0);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_value  = out_value_r;
  assign out_found  = out_found_r;
  assign out_length = out_len_r;
  assign out_empty  = out_empty_r;

endmodule

>>> src/positional_list_engine.sv
// Top level of the positional list engine: controller, datapath and channels.
//
// Requests arrive on in_ch (insert, delete, get, locate, clear with a 1-based
// position and a value); every request gives exactly one transaction on out_ch
// carrying ok, value_out, found_position, length_now and is_empty.
// One request is processed at a time. Insert and delete move one element per
// cycle through the single element RAM port pair; locate reads one element
// per cycle. The next request is accepted from the cycle after the previous
// result is loaded into the output register.
// Reset (synchronous, active low) empties the list and the output register;
// element contents are not cleared and no clearing pass is needed.
// When the receiver stalls, the finished result stays in the output register
// and the next request is still accepted and processed; its result waits in
// the engine until the output register frees.
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  ple_ctl_t ctl;
  ple_sts_t sts;
  logic     in_ready;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ple_dp #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .in_cmd      (in_ch.cmd),
    .in_position (in_ch.position),
    .in_value    (in_ch.value),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ok      (out_ch.ok),
    .out_value   (out_ch.value_out),
    .out_found   (out_ch.found_position),
    .out_length  (out_ch.length_now),
    .out_empty   (out_ch.is_empty)
  );

  assign in_ch.ready = in_ready;

endmodule

>>> verif/ple_result_checker.sv
// Checker for the positional list engine: tracks the list contents and compares every result.
module ple_result_checker import ple_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  logic             req_ready,
  input  logic [CMD_W-1:0] req_cmd,
  input  logic [POS_W-1:0] req_position,
  input  logic [VAL_W-1:0] req_value,
  input  logic             res_valid,
  input  logic             res_ready,
  input  logic             res_ok,
  input  logic [VAL_W-1:0] res_value_out,
  input  logic [LEN_W-1:0] res_found_position,
  input  logic [LEN_W-1:0] res_length_now,
  input  logic             res_is_empty,
  output int               outstanding,
  output int               fail_count
);

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] value_out;
    logic [LEN_W-1:0] found_position;
    logic [LEN_W-1:0] length_now;
    logic             is_empty;
  } list_result_t;

  logic [VAL_W-1:0] list_vals [CAPACITY];
  int               list_len;
  list_result_t     pending_results [$];
  list_result_t     oldest;

  function automatic list_result_t apply_list_request(logic [CMD_W-1:0] cmd, int pos,
                                                      logic [VAL_W-1:0] val);
    list_result_t r;
    int           i;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
          for (i = list_len; i >= pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos-1] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos >= 1 && pos <= list_len) begin
          r.value_out = list_vals[pos-1];
          for (i = pos; i < list_len; i++) list_vals[i-1] = list_vals[i];
          list_len--;
          r.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (pos >= 1 && pos <= list_len) begin
          r.value_out = list_vals[pos-1];
          r.ok = 1'b1;
        end
      end
      CMD_LOCATE: begin
        r.ok = 1'b1;
        for (i = 0; i < list_len; i++)
          if (list_vals[i] == val && r.found_position == '0) r.found_position = LEN_W'(i + 1);
      end
      CMD_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.length_now = LEN_W'(list_len);
    r.is_empty   = (list_len == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      pending_results.delete();
      outstanding = 0;
      fail_count = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("ok", VAL_W'(oldest.ok), VAL_W'(res_ok));
          check_field("value_out", oldest.value_out, res_value_out);
          check_field("found_position", VAL_W'(oldest.found_position), VAL_W'(res_found_position));
          check_field("length_now", VAL_W'(oldest.length_now), VAL_W'(res_length_now));
          check_field("is_empty", VAL_W'(oldest.is_empty), VAL_W'(res_is_empty));
        end
      end
      if (req_valid && req_ready)
        pending_results.push_back(apply_list_request(req_cmd, int'(req_position), req_value));
      outstanding = pending_results.size();
    end
  end

endmodule

>>> verif/tb_positional_list_engine.sv
// Testbench top for the positional list engine: request stimulus, result stalls and verdict.
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int CAPACITY      = 64;
  localparam int REQUESTS      = 1450;
  localparam int SETTLE_CYCLES = 100;
  localparam int LIMIT_CYCLES  = 600000;

  logic        clk;
  logic        rst_n;
  int          outstanding;
  int          fail_count;
  int unsigned cycle_count = 0;
  int          list_len;
  int          sent;
  bit          quiet;

  logic [VAL_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'h0000_0001, 32'h5A5A_A5A5,
                                       32'h0000_00FF, 32'hFF00_0000};

  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  positional_list_engine #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (VAL_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ple_result_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (in_ch.valid),
    .req_ready          (in_ch.ready),
    .req_cmd            (in_ch.cmd),
    .req_position       (in_ch.position),
    .req_value          (in_ch.value),
    .res_valid          (out_ch.valid),
    .res_ready          (out_ch.ready),
    .res_ok             (out_ch.ok),
    .res_value_out      (out_ch.value_out),
    .res_found_position (out_ch.found_position),
    .res_length_now     (out_ch.length_now),
    .res_is_empty       (out_ch.is_empty),
    .outstanding        (outstanding),
    .fail_count         (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_positional_list_engine: FAIL");
      $finish;
    end
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 1) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic int good_position(logic [CMD_W-1:0] c);
    if (c == CMD_INSERT) return $urandom_range(1, list_len + 1);
    return (list_len == 0) ? 1 : $urandom_range(1, list_len);
  endfunction

  function automatic int bad_position(logic [CMD_W-1:0] c);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return (c == CMD_INSERT) ? list_len + 2 : list_len + 1;
      2:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_request(logic [CMD_W-1:0] c, int p, logic [VAL_W-1:0] v);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.position <= p[POS_W-1:0];
    in_ch.value    <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // local length estimate, used to aim positions and to tell when the list is full
    case (c)
      CMD_INSERT: if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) list_len++;
      CMD_DELETE: if (p >= 1 && p <= list_len) list_len--;
      CMD_CLEAR:  list_len = 0;
      default: ;
    endcase
    sent++;
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // mode: 0 grow, 1 shrink, 2 mixed, 3 noise
  task automatic random_request(int mode);
    int               roll;
    logic [CMD_W-1:0] c;
    int               p;
    roll = $urandom_range(0, 99);
    case (mode)
      0: c = (roll < 78) ? CMD_INSERT : (roll < 88) ? CMD_GET :
             (roll < 96) ? CMD_LOCATE : CMD_DELETE;
      1: c = (roll < 60) ? CMD_DELETE : (roll < 80) ? CMD_GET :
             (roll < 92) ? CMD_LOCATE : CMD_INSERT;
      2: begin
        if (roll < 35)      c = CMD_INSERT;
        else if (roll < 55) c = CMD_DELETE;
        else if (roll < 72) c = CMD_GET;
        else if (roll < 88) c = CMD_LOCATE;
        else if (roll < 93) c = CMD_CLEAR;
        else                c = CMD_W'($urandom_range(CMD_CLEAR + 1, 7));
      end
      default: c = CMD_W'($urandom_range(0, 7));
    endcase
    if (mode == 3)                     p = $urandom_range(0, 255);
    else if ($urandom_range(0, 9) == 0) p = bad_position(c);
    else                               p = good_position(c);
    send_request(c, p, (mode == 3) ? $urandom() : pick_value());
  endtask

  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int cmd_code;
    int pick;
    int mode;
    int burst;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_INSERT;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    out_ch.ready   <= 1'b0;
    list_len = 0;
    sent     = 0;
    quiet    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, bad positions, extreme values, duplicates, unknown commands
    send_request(CMD_GET, 1, '0);
    send_request(CMD_DELETE, 1, '0);
    send_request(CMD_LOCATE, 0, '0);
    send_request(CMD_INSERT, 0, 32'h1234_5678);
    send_request(CMD_INSERT, 2, 32'h1234_5678);
    send_request(CMD_INSERT, 1, 32'h8000_0000);
    send_request(CMD_INSERT, 2, 32'h7FFF_FFFF);
    send_request(CMD_INSERT, 1, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 4, 32'h0000_0000);
    send_request(CMD_INSERT, 3, 32'h7FFF_FFFF);
    send_request(CMD_LOCATE, 0, 32'h7FFF_FFFF);
    send_request(CMD_LOCATE, 0, 32'h0000_0001);
    send_request(CMD_GET, 0, '0);
    send_request(CMD_GET, 5, '0);
    send_request(CMD_GET, 6, '0);
    send_request(CMD_DELETE, 255, '0);
    send_request(CMD_DELETE, 2, '0);
    send_request(CMD_INSERT, 255, 32'h5555_AAAA);
    for (cmd_code = CMD_CLEAR + 1; cmd_code < 8; cmd_code++)
      send_request(cmd_code[CMD_W-1:0], 1, 32'hAAAA_5555);
    send_request(CMD_CLEAR, 0, '0);
    send_request(CMD_GET, 1, '0);
    send_request(CMD_LOCATE, 0, 32'hFFFF_FFFF);
    send_request(CMD_CLEAR, 0, '0);
    wait_for_drain();

    // fill to capacity, then hit the full store
    while (list_len < CAPACITY) send_request(CMD_INSERT, good_position(CMD_INSERT), pick_value());
    send_request(CMD_INSERT, 1, pick_value());
    send_request(CMD_INSERT, CAPACITY + 1, pick_value());
    send_request(CMD_LOCATE, 0, pick_value());
    send_request(CMD_GET, CAPACITY, '0);
    send_request(CMD_DELETE, CAPACITY, '0);
    send_request(CMD_DELETE, 1, '0);

    while (sent < REQUESTS) begin
      pick  = $urandom_range(0, 9);
      mode  = (pick < 3) ? 0 : (pick < 5) ? 1 : (pick < 9) ? 2 : 3;
      quiet = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(30, 90);
      repeat (burst) random_request(mode);
      if ($urandom_range(0, 3) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_positional_list_engine: PASS");
    else $display("tb_positional_list_engine: FAIL");
    $finish;
  end

endmodule

>>> sim.f
src/ple_pkg.sv
src/ple_in_if.sv
src/ple_out_if.sv
src/ple_ram.sv
src/ple_ctrl.sv
src/ple_dp.sv
src/positional_list_engine.sv
verif/ple_result_checker.sv
verif/tb_positional_list_engine.sv
